// File: hw/rtl/cmfm_pkg.sv
`timescale 1ns / 1ps

package cmfm_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROT_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_ENABLE  = 3'd4;

  // Reset values of the registers
  localparam logic [15:0] ROT_TIMEOUT_RST = 16'd4000;
  localparam logic [15:0] MAT_TIMEOUT_RST = 16'd5000;
  localparam logic [7:0]  WORK_SPEED_RST  = 8'd0;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_ROT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  // floor(x / 500) == (x * BLINK_MUL) >> BLINK_SHIFT for every 32-bit x.
  // (x mod 1000) < 500 exactly when that quotient is even.
  localparam int          BLINK_MUL_W = 29;
  localparam logic [28:0] BLINK_MUL   = 29'h10624DD3;
  localparam int          BLINK_SHIFT = 37;
  localparam int          BLINK_PROD_W = NOW_W + BLINK_MUL_W;

  typedef struct packed {
    logic [15:0] rotation_timeout_ms;
    logic [15:0] material_timeout_ms;
    logic [7:0]  work_speed;
    logic        rotation_check_enable;
    logic        material_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic [15:0]      rotation_freq;
    logic             conveyor_on;
    logic [7:0]       vehicle_speed;
    logic [3:0]       spread_width;
    logic [15:0]      spread_density;
    logic             pto_on;
    logic             clutch_engaged;
    logic             material_flag;
    logic             dump_on;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] icon;
    logic       status_changed;
  } res_t;

endpackage

// File: hw/rtl/cmfm_cfg_regs.sv
`timescale 1ns / 1ps

module cmfm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [cmfm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [cmfm_pkg::CFG_DATA_W-1:0]   wr_data,
  output cmfm_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation_timeout_ms   <= cmfm_pkg::ROT_TIMEOUT_RST;
      cfg.material_timeout_ms   <= cmfm_pkg::MAT_TIMEOUT_RST;
      cfg.work_speed            <= cmfm_pkg::WORK_SPEED_RST;
      cfg.rotation_check_enable <= 1'b1;
      cfg.material_check_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        cmfm_pkg::REG_ROT_TIMEOUT: cfg.rotation_timeout_ms   <= wr_data;
        cmfm_pkg::REG_MAT_TIMEOUT: cfg.material_timeout_ms   <= wr_data;
        cmfm_pkg::REG_WORK_SPEED:  cfg.work_speed            <= wr_data[7:0];
        cmfm_pkg::REG_ROT_ENABLE:  cfg.rotation_check_enable <= wr_data[0];
        cmfm_pkg::REG_MAT_ENABLE:  cfg.material_check_enable <= wr_data[0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

// File: hw/rtl/cmfm_core.sv
`timescale 1ns / 1ps

module cmfm_core #(
  parameter int TIME_BITS = cmfm_pkg::TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  cmfm_pkg::cfg_t  cfg,
  input  cmfm_pkg::item_t item,
  output cmfm_pkg::res_t  res
);

  localparam int NW = cmfm_pkg::NOW_W;
  localparam logic [NW-1:0] NOW_MASK =
    (TIME_BITS >= NW) ? {NW{1'b1}} : NW'((64'd1 << TIME_BITS) - 64'd1);

  logic [TIME_BITS-1:0] rot_stamp;
  logic [TIME_BITS-1:0] dump_stamp;
  logic [TIME_BITS-1:0] mat_stamp;
  logic [1:0]           last_status;
  logic                 last_valid;

  logic [TIME_BITS+NW-1:0] now_wide;
  logic [TIME_BITS-1:0]    now_t;
  logic [NW-1:0]           now_m;
  logic [TIME_BITS-1:0]    age_rot, age_dump, age_mat;
  logic [TIME_BITS-1:0]    rto, mto;
  logic rotating, slow, width_zero, density_zero, idle_conv, run_conv;
  logic rot_refresh, dump_refresh, mat_refresh;
  logic rot_stale, dump_stale, mat_stale, no_rot;
  logic [cmfm_pkg::BLINK_PROD_W-1:0] blink_prod;
  logic [1:0] status;

  assign now_wide = {{TIME_BITS{1'b0}}, item.now_ms};
  assign now_t    = now_wide[TIME_BITS-1:0];
  assign now_m    = item.now_ms & NOW_MASK;

  assign rotating     = (item.rotation_freq != '0);
  assign slow         = (item.vehicle_speed == '0) || (cfg.work_speed >= item.vehicle_speed);
  assign width_zero   = (item.spread_width == '0);
  assign density_zero = (item.spread_density == '0);
  assign idle_conv    = !rotating && item.conveyor_on;
  assign run_conv     = rotating && item.conveyor_on;

  // Refresh rules: the sensor cannot or need not be judged on this word
  assign rot_refresh = !idle_conv || slow || width_zero || !cfg.rotation_check_enable ||
                       (item.pto_on && !item.clutch_engaged);
  assign dump_refresh = !(!rotating && item.dump_on) || !cfg.rotation_check_enable;

  always_comb begin
    if (run_conv) begin
      mat_refresh = !item.material_flag || !cfg.material_check_enable;
    end else if (idle_conv) begin
      mat_refresh = slow || density_zero ||
                    (!cfg.rotation_check_enable && !item.material_flag) ||
                    (item.material_flag && !cfg.material_check_enable);
    end else begin
      mat_refresh = 1'b1;
    end
  end

  assign age_rot  = now_t - rot_stamp;
  assign age_dump = now_t - dump_stamp;
  assign age_mat  = now_t - mat_stamp;
  assign rto      = TIME_BITS'(cfg.rotation_timeout_ms);
  assign mto      = TIME_BITS'(cfg.material_timeout_ms);

  // A refreshed stamp has age zero and is never stale
  assign rot_stale  = !rot_refresh && (age_rot > rto);
  assign dump_stale = item.dump_on && !dump_refresh && (age_dump > rto);
  assign no_rot     = rot_stale || dump_stale;
  assign mat_stale  = item.material_flag && !mat_refresh && (age_mat > mto);

  always_comb begin
    priority if (no_rot) begin
      status = cmfm_pkg::ST_NO_ROT;
    end else if (mat_stale) begin
      status = cmfm_pkg::ST_EMPTY;
    end else begin
      status = cmfm_pkg::ST_OK;
    end
  end

  assign blink_prod = cmfm_pkg::BLINK_PROD_W'(now_m) *
                      cmfm_pkg::BLINK_PROD_W'(cmfm_pkg::BLINK_MUL);

  always_comb begin
    res.status         = status;
    res.status_changed = !last_valid || (status != last_status);
    if ((status == cmfm_pkg::ST_EMPTY) && !blink_prod[cmfm_pkg::BLINK_SHIFT]) begin
      res.icon = cmfm_pkg::ST_OK;
    end else begin
      res.icon = status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_stamp   <= '0;
      dump_stamp  <= '0;
      mat_stamp   <= '0;
      last_status <= cmfm_pkg::ST_OK;
      last_valid  <= 1'b0;
    end else if (fire) begin
      if (rot_refresh) begin
        rot_stamp <= now_t;
      end
      if (dump_refresh) begin
        dump_stamp <= now_t;
      end
      if (mat_refresh || no_rot) begin
        mat_stamp <= now_t;
      end
      last_status <= status;
      last_valid  <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/conveyor_material_fault_monitor_unit.sv
`timescale 1ns / 1ps

// Conveyor and material fault monitor. Each input word is a sensor snapshot
// stamped with a wrapping millisecond time; the block answers every word with
// exactly one result word: status (0 ok, 1 no rotation, 2 material empty), a
// display icon that blinks empty to ok while now_ms mod 1000 is below 500,
// and status_changed, set on the first result after reset and whenever the
// status differs from the previous one. Three last-healthy stamps (rotation,
// dump, material) live in the evaluation stage; a stamp is refreshed whenever
// its sensor cannot or need not be judged, and a fault needs its age, taken
// unsigned modulo 2^TIME_BITS, strictly above the configured timeout. Words
// go through an input register and a result register, so one word is
// accepted every clock while the output is not stalled; out_valid rises once
// a word has passed the input register and been evaluated into the result
// register. The result register sits between the two channels, and the
// input stalls only while both registers are full and the output is stalled.
// The stamp update is the loop that sets this rate: it closes through three
// subtract-and-compare paths; the blink multiplier sits beside that loop and
// only feeds the icon. Write configuration only while the block is idle;
// cfg_ready is always high and writes to unmapped indexes are dropped.

module conveyor_material_fault_monitor_unit #(
  parameter int TIME_BITS = cmfm_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cmfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmfm_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cmfm_pkg::NOW_W-1:0]      now_ms,
  input  logic [15:0]                     rotation_freq,
  input  logic                            conveyor_on,
  input  logic [7:0]                      vehicle_speed,
  input  logic [3:0]                      spread_width,
  input  logic [15:0]                     spread_density,
  input  logic                            pto_on,
  input  logic                            clutch_engaged,
  input  logic                            material_flag,
  input  logic                            dump_on,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [1:0]                      icon,
  output logic                            status_changed
);

  cmfm_pkg::cfg_t  cfg;
  cmfm_pkg::item_t item;
  cmfm_pkg::res_t  res_next;
  logic            item_valid;
  logic            out_free;
  logic            fire;
  logic            in_take;

  assign cfg_ready = 1'b1;

  cmfm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register: load on accept, clear once its word moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.now_ms         <= now_ms;
      item.rotation_freq  <= rotation_freq;
      item.conveyor_on    <= conveyor_on;
      item.vehicle_speed  <= vehicle_speed;
      item.spread_width   <= spread_width;
      item.spread_density <= spread_density;
      item.pto_on         <= pto_on;
      item.clutch_engaged <= clutch_engaged;
      item.material_flag  <= material_flag;
      item.dump_on        <= dump_on;
    end
  end

  cmfm_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .item (item),
    .res  (res_next)
  );

  // Result register: hold while stalled, advance when the stage fires.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= res_next.status;
      icon           <= res_next.icon;
      status_changed <= res_next.status_changed;
    end
  end

endmodule

// File: hw/rtl/cmfm_checker.sv
`timescale 1ns / 1ps

module cmfm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [1:0] icon
);

  // Input backs up only behind a full, stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output can drain");

  // Icon differs from status only for the blinking empty status.
  a_icon_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != cmfm_pkg::ST_EMPTY) |-> (icon == status))
    else $error("icon differs from a non-empty status");

  a_icon_blink: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cmfm_pkg::ST_EMPTY) |->
      (icon == cmfm_pkg::ST_EMPTY || icon == cmfm_pkg::ST_OK))
    else $error("empty status shows a wrong icon");

  // Accepted word with an empty output passes the input register and then shows a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
    else $error("result missing after accepted word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(icon)))
    else $error("stalled result changed");

endmodule

bind conveyor_material_fault_monitor_unit cmfm_checker u_cmfm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .icon      (icon)
);
